// File: hw/rtl/mpq_pkg.sv
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared types, constants and helpers of the minimum priority queue.
// ----------------------------------------------------------------------------
package mpq_pkg;

    localparam int DEPTH   = 64;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 6;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_DONE
    } seq_state_t;

    // One write port and one read port of the entry store.
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } mem_req_t;

    typedef struct packed {
        logic [DATA_W-1:0]  min_value;
        status_t            status;
        logic [COUNT_W-1:0] count;
    } result_t;

    // Low COUNT_W bits of an entry count, zero extended when the count is narrower.
    function automatic logic [COUNT_W-1:0] count_out(input logic [ADDR_W-1:0] cnt);
        logic [31:0] wide;
        wide = 32'(cnt);
        return wide[COUNT_W-1:0];
    endfunction

endpackage

// File: hw/rtl/mpq_ram.sv
// ----------------------------------------------------------------------------
// mpq_ram
// Entry store: simple dual-port memory with a registered read port.
// ----------------------------------------------------------------------------
module mpq_ram (
    input  logic                      aclk,
    input  mpq_pkg::mem_req_t         req,
    output logic [mpq_pkg::DATA_W-1:0] rd_data
);
    import mpq_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/mpq_seq.sv
// ----------------------------------------------------------------------------
// mpq_seq
// Sequencer: insert, minimum scan and gap-closing shift over the entry store.
// ----------------------------------------------------------------------------
module mpq_seq (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_op,
    input  logic [mpq_pkg::DATA_W-1:0] s_value,
    output mpq_pkg::mem_req_t          mem_req,
    input  logic [mpq_pkg::DATA_W-1:0] rd_data,
    output logic                       res_valid,
    input  logic                       res_ready,
    output mpq_pkg::result_t           res
);
    import mpq_pkg::*;

    seq_state_t        state_reg, state_next;
    logic [ADDR_W-1:0] count_reg, count_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic              rd_valid_reg, rd_valid_next;
    logic [ADDR_W-1:0] rd_idx_reg, rd_idx_next;
    logic [DATA_W-1:0] best_val_reg, best_val_next;
    logic [ADDR_W-1:0] best_idx_reg, best_idx_next;
    result_t           res_reg, res_next;

    logic              take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        rd_idx_reg   <= rd_idx_next;
        best_val_reg <= best_val_next;
        best_idx_reg <= best_idx_next;
        res_reg      <= res_next;
    end

    // Strictly smaller wins, so the earliest of equal minima is kept.
    assign take = (rd_idx_reg == '0) || ($signed(rd_data) < $signed(best_val_reg));

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        rd_valid_next = 1'b0;
        rd_idx_next   = rd_idx_reg;
        best_val_next = best_val_reg;
        best_idx_next = best_idx_reg;
        res_next      = res_reg;
        mem_req       = '0;
        s_ready       = 1'b0;
        res_valid     = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_op == OP_INSERT) begin
                        if (count_reg == ADDR_W'(DEPTH - 1)) begin
                            res_next = '{min_value: '0, status: STATUS_FULL,
                                         count: count_out(count_reg)};
                        end else begin
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = count_reg;
                            mem_req.wr_data = s_value;
                            count_next      = count_reg + ADDR_W'(1);
                            res_next = '{min_value: '0, status: STATUS_OK,
                                         count: count_out(count_reg + ADDR_W'(1))};
                        end
                        state_next = ST_DONE;
                    end else if (count_reg == '0) begin
                        res_next   = '{min_value: '0, status: STATUS_EMPTY,
                                       count: count_out(count_reg)};
                        state_next = ST_DONE;
                    end else begin
                        idx_next   = '0;
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN: begin
                if (idx_reg != count_reg) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = idx_reg;
                    rd_valid_next   = 1'b1;
                    rd_idx_next     = idx_reg;
                    idx_next        = idx_reg + ADDR_W'(1);
                end
                if (rd_valid_reg) begin
                    if (take) begin
                        best_val_next = rd_data;
                        best_idx_next = rd_idx_reg;
                    end
                    if (rd_idx_reg == count_reg - ADDR_W'(1)) begin
                        idx_next   = (take ? rd_idx_reg : best_idx_reg) + ADDR_W'(1);
                        state_next = ST_SHIFT;
                    end
                end
            end

            ST_SHIFT: begin
                // Read entry i and write it to i-1 in the following cycle.
                if (idx_reg != count_reg) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = idx_reg;
                    rd_valid_next   = 1'b1;
                    rd_idx_next     = idx_reg;
                    idx_next        = idx_reg + ADDR_W'(1);
                end
                if (rd_valid_reg) begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = rd_idx_reg - ADDR_W'(1);
                    mem_req.wr_data = rd_data;
                end
                if ((idx_reg == count_reg) && !rd_valid_reg) begin
                    count_next = count_reg - ADDR_W'(1);
                    res_next   = '{min_value: best_val_reg, status: STATUS_OK,
                                   count: count_out(count_reg - ADDR_W'(1))};
                    state_next = ST_DONE;
                end
            end

            ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res = res_reg;

endmodule

// File: hw/rtl/min_priority_queue_core.sv
// ----------------------------------------------------------------------------
// min_priority_queue_core
// Unsorted array priority queue of signed 32-bit values with remove-minimum.
// ----------------------------------------------------------------------------
// Usage: each input item carries s_op and s_value. An insert (s_op = 0)
// appends s_value behind the entries already held; a remove (s_op = 1)
// returns the smallest held value, the earliest inserted one among equals.
// At most DEPTH-1 entries are held. A full insert is dropped with status 1,
// and a remove from an empty queue returns 0 with status 2. Every item gives
// exactly one result item with m_min_value, m_status and m_count, the count
// of entries held after the item.
// Both channels use valid/ready. Items are processed one at a time by the
// sequencer. An insert or a rejected item passes the sequencer's result
// register and the output register before it leaves the core. A remove of
// the entry at index b from n held entries scans all n entries, one memory
// read per cycle, then shifts the entries behind the minimum down one per
// cycle through the single read and single write port of the entry store.
// The next item is accepted at the earliest at the edge where the previous
// result can leave, so back-to-back inserts do not overlap in the sequencer.
// A result waits in the output register when m_ready is low while the next
// item is already accepted and processed; that item then waits for the
// output register to drain. Synchronous active-low reset empties the queue;
// the entry store itself is not cleared.
// ----------------------------------------------------------------------------
module min_priority_queue_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_op,
    input  logic signed [31:0]           s_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [31:0]           m_min_value,
    output logic [1:0]                   m_status,
    output logic [5:0]                   m_count
);
    import mpq_pkg::*;

    mem_req_t          mem_req;
    logic [DATA_W-1:0] rd_data;
    logic              res_valid;
    logic              res_ready;
    result_t           res;

    logic              m_valid_reg;
    result_t           m_res_reg;

    // Entry store in a synchronous memory; reads land in the next cycle.
    mpq_ram u_ram (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    // Sequencer: handles inserts directly and runs the scan and shift of a
    // remove through the memory ports.
    mpq_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_op      (s_op),
        .s_value   (s_value),
        .mem_req   (mem_req),
        .rd_data   (rd_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register: it is free when empty or being taken this cycle.
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_min_value = m_res_reg.min_value;
    assign m_status    = m_res_reg.status;
    assign m_count     = m_res_reg.count;

endmodule

// File: test/mpq_score_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpq_score_pkg
// Result checker for the minimum priority queue: it keeps its own copy of the
// held entries and compares every result item with the expected one.
// ----------------------------------------------------------------------------
package mpq_score_pkg;

    import mpq_pkg::*;

    class min_queue_scoreboard;
        int unsigned        capacity;
        logic signed [31:0] held_values[$];
        result_t            pending_results[$];
        int unsigned        errors;
        int unsigned        checked;
        int unsigned        inserts;
        int unsigned        removes;
        int unsigned        full_drops;
        int unsigned        empty_removes;
        int unsigned        peak_fill;

        function new();
            capacity      = DEPTH - 1;
            errors        = 0;
            checked       = 0;
            inserts       = 0;
            removes       = 0;
            full_drops    = 0;
            empty_removes = 0;
            peak_fill     = 0;
        endfunction

        function int unsigned fill();
            return held_values.size();
        endfunction

        function int unsigned outstanding();
            return pending_results.size();
        endfunction

        // Applies one accepted item to the queue copy and queues its result.
        function void note_item(logic op, logic signed [31:0] value);
            result_t expected;
            int      best;
            expected.min_value = '0;
            expected.status    = STATUS_OK;
            if (op == OP_INSERT) begin
                if (held_values.size() >= capacity) begin
                    expected.status = STATUS_FULL;
                    full_drops++;
                end else begin
                    held_values.push_back(value);
                    inserts++;
                end
            end else if (held_values.size() == 0) begin
                expected.status = STATUS_EMPTY;
                empty_removes++;
            end else begin
                // Strict less-than keeps the earliest of equal minima.
                best = 0;
                for (int i = 1; i < held_values.size(); i++) begin
                    if (held_values[i] < held_values[best]) begin
                        best = i;
                    end
                end
                expected.min_value = held_values[best];
                held_values.delete(best);
                removes++;
            end
            expected.count = COUNT_W'(held_values.size());
            if (held_values.size() > peak_fill) begin
                peak_fill = held_values.size();
            end
            pending_results.push_back(expected);
        endfunction

        function void check_result(logic signed [31:0] min_value, logic [1:0] status,
                                   logic [5:0] count);
            result_t expected;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: min_value %0d status %0d count %0d",
                         $time, min_value, status, count);
                return;
            end
            expected = pending_results.pop_front();
            checked++;
            if (min_value !== expected.min_value) begin
                errors++;
                $display("%0t: min_value mismatch: expected %0d, actual %0d", $time,
                         $signed(expected.min_value), min_value);
            end
            if (status !== 2'(expected.status)) begin
                errors++;
                $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                         2'(expected.status), status);
            end
            if (count !== expected.count) begin
                errors++;
                $display("%0t: count mismatch: expected %0d, actual %0d", $time,
                         expected.count, count);
            end
        endfunction
    endclass

endpackage

// File: test/min_priority_queue_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_priority_queue_core_test
// Self-checking bench for the minimum priority queue core. A short directed
// sequence hits the empty corner, the value extremes and equal minima; then
// randomized fill, drain and mixed sequences run with random idle bursts on
// both channels and a long result back-pressure stretch.
// ----------------------------------------------------------------------------
module min_priority_queue_core_test;

    import mpq_pkg::*;
    import mpq_score_pkg::*;

    // The slowest remove scans and shifts a full queue; 1300 items with stalls
    // and the long hold stay well under a fifth of this limit.
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned ITEM_TARGET  = 1300;
    localparam int unsigned QUIET_START  = 1150;
    localparam int unsigned LONG_HOLD    = 300;
    localparam int unsigned TAIL_CYCLES  = 16;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_op;
    logic signed [31:0] s_value;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_min_value;
    logic [1:0]         m_status;
    logic [5:0]         m_count;

    min_queue_scoreboard sb;
    int unsigned         items_sent;
    int unsigned         cycle_count;
    bit                  idle_enable;
    bit                  hold_request;

    min_priority_queue_core u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_min_value (m_min_value),
        .m_status    (m_status),
        .m_count     (m_count)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("Timeout after %0d cycles with %0d results outstanding.",
                         cycle_count, sb.outstanding());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Result monitor. Outputs are sampled at the rising edge; m_ready is
    // driven by the bench at the falling edge, so both are stable here.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_min_value, m_status, m_count);
        end
    end

    // Result receiver. It stalls in random short bursts while idling is
    // enabled, and on request holds m_ready low for a long stretch so that
    // the output register fills and the core stops taking items.
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        m_ready    = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (hold_request) begin
                hold_request = 1'b0;
                m_ready     <= 1'b0;
                stall_left   = LONG_HOLD - 1;
            end else if (idle_enable && $urandom_range(0, 3) == 0) begin
                m_ready   <= 1'b0;
                stall_left = $urandom_range(1, 3) - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Offers one item and returns at the falling edge after it was taken.
    // Valid is only dropped when an idle burst is inserted, so it never
    // toggles within one time step.
    task automatic send_item(input logic op, input logic signed [31:0] value);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_op    <= op;
        s_value <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_item(op, value);
        items_sent++;
        @(negedge aclk);
    endtask

    // Holds the input side quiet until every expected result has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.outstanding() != 0) @(negedge aclk);
    endtask

    // Value mix: full-range words, a narrow band that produces many equal
    // minima, the signed extremes, and a moderate band around zero.
    function automatic logic signed [31:0] random_value();
        logic signed [31:0] value;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: value = $urandom;
            4, 5:       value = $signed($urandom_range(0, 15)) - 8;
            6: begin
                case ($urandom_range(0, 3))
                    0:       value = 32'sh8000_0000;
                    1:       value = 32'sh7FFF_FFFF;
                    2:       value = 32'sd0;
                    default: value = -32'sd1;
                endcase
            end
            default:    value = $signed($urandom_range(0, 2000)) - 1000;
        endcase
        return value;
    endfunction

    // Mixed traffic, leaning slightly toward inserts so the fill wanders.
    task automatic run_mixed(input int unsigned n);
        for (int unsigned k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < 55) begin
                send_item(OP_INSERT, random_value());
            end else begin
                send_item(OP_REMOVE, $urandom);
            end
        end
    endtask

    // Fills the queue to capacity, then pushes a few inserts that must drop.
    task automatic run_fill();
        while (sb.fill() < DEPTH - 1) send_item(OP_INSERT, random_value());
        repeat ($urandom_range(1, 3)) send_item(OP_INSERT, random_value());
    endtask

    // Empties the queue, then removes a few times more from the empty queue.
    task automatic run_drain();
        while (sb.fill() > 0) send_item(OP_REMOVE, $urandom);
        repeat ($urandom_range(1, 3)) send_item(OP_REMOVE, $urandom);
    endtask

    initial begin
        logic               dir_op[$];
        logic signed [31:0] dir_value[$];

        sb           = new();
        items_sent   = 0;
        idle_enable  = 1'b1;
        hold_request = 1'b0;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_op         = OP_INSERT;
        s_value      = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part. It opens with a remove from the empty queue, loads
        // the signed extremes, zero, minus one and two alternating bit
        // patterns, and repeats the most negative value so that a pair of
        // equal minima must come out earliest first. The drain that follows
        // runs past empty once more.
        dir_op    = '{OP_REMOVE, OP_INSERT, OP_INSERT, OP_INSERT, OP_INSERT,
                      OP_INSERT, OP_INSERT, OP_INSERT, OP_INSERT, OP_REMOVE,
                      OP_REMOVE, OP_REMOVE, OP_REMOVE, OP_REMOVE, OP_REMOVE,
                      OP_REMOVE, OP_REMOVE, OP_REMOVE, OP_REMOVE};
        dir_value = '{32'sh1234_5678, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0,
                      -32'sd1, 32'sd1, 32'sh8000_0000, 32'sh5555_5555,
                      32'shAAAA_AAAA, 32'sh7FFF_FFFF, 32'sh0, -32'sd1,
                      32'sh5555_5555, 32'shAAAA_AAAA, 32'sd0, 32'sd1,
                      32'sd2, 32'sd3, -32'sd4};
        foreach (dir_op[i]) begin
            send_item(dir_op[i], dir_value[i]);
        end
        wait_drained();

        // Guaranteed trip through both corners before the random mix.
        run_mixed(30);
        run_fill();
        run_drain();
        wait_drained();

        // Long back-pressure: the receiver holds off while the sender keeps
        // offering inserts, so the core stalls its input until the hold ends.
        hold_request = 1'b1;
        repeat (12) send_item(OP_INSERT, random_value());
        run_mixed(20);

        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= QUIET_START) begin
                idle_enable = 1'b0;
            end else begin
                idle_enable = ($urandom_range(0, 3) != 0);
            end
            case ($urandom_range(0, 9))
                0: run_fill();
                1: run_drain();
                2: begin
                    run_drain();
                    wait_drained();
                end
                default: run_mixed($urandom_range(10, 40));
            endcase
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge aclk);

        $display("Stimulus: %0d items, %0d inserts, %0d removes, %0d dropped on full,",
                 items_sent, sb.inserts, sb.removes, sb.full_drops);
        $display("%0d removes on empty, peak fill %0d; %0d results checked, %0d mismatches.",
                 sb.empty_removes, sb.peak_fill, sb.checked, sb.errors);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
